// ===== rtl/sme_pkg.sv =====
// Shared types and constants of the stack machine execute unit.
package sme_pkg;

    localparam int WORD_BITS = 32;
    localparam int OP_BITS   = 5;
    localparam int ADDR_BITS = 16;
    localparam int INB_BITS  = 9;
    localparam int LIU_BITS  = 9;
    localparam int DEP_BITS  = 7;
    localparam int ERR_BITS  = 3;
    localparam int IN_TDATA_BITS  = 64;
    localparam int OUT_TDATA_BITS = 64;

    localparam logic [OP_BITS-1:0] OP_NOP  = 5'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD = 5'd1;
    localparam logic [OP_BITS-1:0] OP_PUSH = 5'd2;
    localparam logic [OP_BITS-1:0] OP_STORE = 5'd3;
    localparam logic [OP_BITS-1:0] OP_DUP  = 5'd4;
    localparam logic [OP_BITS-1:0] OP_POP  = 5'd5;
    localparam logic [OP_BITS-1:0] OP_INC  = 5'd6;
    localparam logic [OP_BITS-1:0] OP_DEC  = 5'd7;
    localparam logic [OP_BITS-1:0] OP_ADD  = 5'd8;
    localparam logic [OP_BITS-1:0] OP_SUB  = 5'd9;
    localparam logic [OP_BITS-1:0] OP_MUL  = 5'd10;
    localparam logic [OP_BITS-1:0] OP_DIV  = 5'd11;
    localparam logic [OP_BITS-1:0] OP_REM  = 5'd12;
    localparam logic [OP_BITS-1:0] OP_AND  = 5'd13;
    localparam logic [OP_BITS-1:0] OP_OR   = 5'd14;
    localparam logic [OP_BITS-1:0] OP_XOR  = 5'd15;
    localparam logic [OP_BITS-1:0] OP_NOT  = 5'd16;
    localparam logic [OP_BITS-1:0] OP_NEG  = 5'd17;
    localparam logic [OP_BITS-1:0] OP_SHL  = 5'd18;
    localparam logic [OP_BITS-1:0] OP_SHR  = 5'd19;
    localparam logic [OP_BITS-1:0] OP_CMP  = 5'd20;
    localparam logic [OP_BITS-1:0] OP_JMP  = 5'd21;
    localparam logic [OP_BITS-1:0] OP_JE   = 5'd22;
    localparam logic [OP_BITS-1:0] OP_JNE  = 5'd23;
    localparam logic [OP_BITS-1:0] OP_JG   = 5'd24;
    localparam logic [OP_BITS-1:0] OP_JGE  = 5'd25;
    localparam logic [OP_BITS-1:0] OP_JL   = 5'd26;
    localparam logic [OP_BITS-1:0] OP_JLE  = 5'd27;
    localparam logic [OP_BITS-1:0] OP_IN   = 5'd28;
    localparam logic [OP_BITS-1:0] OP_OUT  = 5'd29;
    localparam logic [OP_BITS-1:0] OP_RET  = 5'd30;

    localparam logic [ERR_BITS-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_UNDER  = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_OVER   = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_LOCAL  = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_DIVZ   = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_JUMP   = 3'd5;
    localparam logic [ERR_BITS-1:0] ERR_BADOP  = 3'd6;

    localparam logic [3:0] F_NE = 4'd1;
    localparam logic [3:0] F_EQ = 4'd2;
    localparam logic [3:0] F_GT = 4'd4;
    localparam logic [3:0] F_LT = 4'd8;

    localparam logic REG_LOCALS_IN_USE = 1'b0;
    localparam logic REG_CODE_SIZE     = 1'b1;

    typedef struct packed {
        logic capture;
        logic commit;
        logic div_start;
    } sme_cmd_t;

    typedef struct packed {
        logic div_need;
        logic div_done;
        logic out_busy;
    } sme_sts_t;

endpackage

// ===== rtl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit.
//
// One decoded instruction arrives per item on the s_ channel; one result item
// leaves on the m_ channel for each. Configuration registers locals_in_use
// (index 0) and code_size (index 1) are written through cfg_we, cfg_index
// and cfg_wdata; the user must write them only while the unit is idle, and
// the unit does not enforce this. An accepted item goes through a registered
// read of the two stack entries below the top and of the local slot, then
// execute and write back; only then is a new item accepted. div and rem run
// an iterative divider before write back, one quotient bit per cycle. The
// result register lets the next item be accepted while the previous result
// waits; if the receiver stalls, the following instruction holds in execute
// until the result register frees. Reset empties the stack, clears the
// compare flags, both configuration registers and the valid bits of the
// local store, so every local reads as zero until it is written.
module stack_machine_execute_unit
#(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_SLOTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[4:0], operand[36:5], instr_addr[52:37], in_byte[61:53], zero[63:62]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // value[31:0], out_valid[32], returned[33], jump_taken[34],
    // jump_target[50:35], stack_depth[57:51], error[60:58], zero[63:61]
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    sme_pkg::sme_cmd_t cmd;
    sme_pkg::sme_sts_t sts;

    sme_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sme_dp
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_SLOTS (LOCAL_SLOTS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_vld   (m_tvalid),
        .out_rdy   (m_tready),
        .out_data  (m_tdata)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_error_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[60:58] != sme_pkg::ERR_NONE) |-> (m_tdata[34:32] == 3'd0))
        else $error("error result carries an action flag");

    a_ret_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[57:51] == 7'd0))
        else $error("return left entries on the stack");

endmodule

// ===== rtl/sme_div.sv =====
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module sme_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sme_pkg::WORD_BITS-1:0]  dividend,
    input  logic [sme_pkg::WORD_BITS-1:0]  divisor,
    output logic                           done,
    output logic [sme_pkg::WORD_BITS-1:0]  quot,
    output logic [sme_pkg::WORD_BITS-1:0]  rem
);
    localparam int W  = sme_pkg::WORD_BITS;
    localparam int NW = $clog2(W);

    logic          busy_reg;
    logic [NW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W:0]    r_reg;
    logic [W:0]    rs;
    logic          ge;

    assign rs   = {r_reg[W-1:0], q_reg[W-1]};
    assign ge   = rs >= {1'b0, divisor};
    assign done = !busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + NW'(1);
            if (cnt_reg == NW'(W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? (rs - {1'b0, divisor}) : rs;
            q_reg <= {q_reg[W-2:0], ge};
        end
    end

endmodule

// ===== rtl/sme_ctrl.sv =====
// Controller state machine sequencing capture, read, execute and divide.
module sme_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sme_pkg::sme_sts_t sts,
    output sme_pkg::sme_cmd_t cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sts.div_need)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done && !sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sme_dp.sv =====
// Datapath: operand stack, local store, flags, ALU, divider and result register.
module sme_dp
#(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_SLOTS = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sme_pkg::sme_cmd_t                     cmd,
    output sme_pkg::sme_sts_t                     sts,
    input  logic [sme_pkg::IN_TDATA_BITS-1:0]     in_data,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [15:0]                           cfg_wdata,
    output logic                                  out_vld,
    input  logic                                  out_rdy,
    output logic [sme_pkg::OUT_TDATA_BITS-1:0]    out_data
);
    localparam int W  = sme_pkg::WORD_BITS;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

    logic [4:0]    op_reg;
    logic [W-1:0]  opnd_reg;
    logic [15:0]   addr_reg;
    logic [8:0]    inb_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  tos_reg;
    logic [3:0]    flags_reg;
    logic [8:0]    liu_reg;
    logic [15:0]   csz_reg;

    logic [W-1:0]  stk_mem [STACK_DEPTH];
    logic [W-1:0]  rdb_reg;
    logic [W-1:0]  rdc_reg;
    logic [W-1:0]  lcl_mem [LOCAL_SLOTS];
    logic [LOCAL_SLOTS-1:0] lvalid_reg;
    logic [W-1:0]  lrd_reg;
    logic          lvld_reg;

    logic          ovld_reg;
    logic [sme_pkg::OUT_TDATA_BITS-1:0] odata_reg;

    logic [AW-1:0] idx_b;
    logic [AW-1:0] idx_c;
    logic [LW-1:0] lidx;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  c;
    logic [W-1:0]  lval;
    logic [1:0]    need;
    logic          idx_bad;
    logic          full;
    logic          take;
    logic [33:0]   tgt;
    logic          tgt_bad;
    logic [2:0]    err;
    logic          is_div;
    logic [W-1:0]  ua;
    logic [W-1:0]  ub;
    logic          d_done;
    logic [W-1:0]  d_q;
    logic [W-1:0]  d_r;
    logic [W-1:0]  alu_r;

    logic [CW-1:0] new_cnt;
    logic [W-1:0]  new_tos;
    logic          stk_we;
    logic [AW-1:0] widx;
    logic [W-1:0]  wval;
    logic          lcl_we;
    logic          flags_we;
    logic [3:0]    new_flags;
    logic          val_set;
    logic [W-1:0]  value;
    logic          outv;
    logic          ret;
    logic          jt;
    logic [15:0]   target;

    assign a     = tos_reg;
    assign b     = rdb_reg;
    assign c     = rdc_reg;
    assign lval  = lvld_reg ? lrd_reg : '0;
    assign idx_b = AW'(cnt_reg - CW'(2));
    assign idx_c = AW'(cnt_reg - CW'(3));
    assign lidx  = opnd_reg[LW-1:0];
    assign ua    = a[W-1] ? (-a) : a;
    assign ub    = b[W-1] ? (-b) : b;

    sme_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ub),
        .divisor  (ua),
        .done     (d_done),
        .quot     (d_q),
        .rem      (d_r)
    );

    always_comb
    begin
        need = 2'd0;
        case (op_reg)
            sme_pkg::OP_DUP, sme_pkg::OP_POP, sme_pkg::OP_INC, sme_pkg::OP_DEC,
            sme_pkg::OP_NOT, sme_pkg::OP_NEG, sme_pkg::OP_OUT:
                need = 2'd1;
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_REM, sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_XOR,
            sme_pkg::OP_SHL, sme_pkg::OP_SHR, sme_pkg::OP_CMP:
                need = 2'd2;
            default:
                need = 2'd0;
        endcase

        case (op_reg)
            sme_pkg::OP_JMP: take = 1'b1;
            sme_pkg::OP_JE:  take = (flags_reg & sme_pkg::F_EQ) != 4'd0;
            sme_pkg::OP_JNE: take = (flags_reg & sme_pkg::F_NE) != 4'd0;
            sme_pkg::OP_JG:  take = (flags_reg & sme_pkg::F_GT) != 4'd0;
            sme_pkg::OP_JGE: take = (flags_reg & (sme_pkg::F_GT | sme_pkg::F_EQ)) != 4'd0;
            sme_pkg::OP_JL:  take = (flags_reg & sme_pkg::F_LT) != 4'd0;
            sme_pkg::OP_JLE: take = (flags_reg & (sme_pkg::F_LT | sme_pkg::F_EQ)) != 4'd0;
            default:         take = 1'b0;
        endcase

        idx_bad = (opnd_reg >= W'(liu_reg)) || (opnd_reg >= W'(LOCAL_SLOTS));
        full    = cnt_reg >= CW'(STACK_DEPTH);
        tgt     = {18'd0, addr_reg} + {{2{opnd_reg[W-1]}}, opnd_reg};
        tgt_bad = tgt[33] || (tgt[32:0] > {17'd0, csz_reg});
        is_div  = (op_reg == sme_pkg::OP_DIV) || (op_reg == sme_pkg::OP_REM);

        err = sme_pkg::ERR_NONE;
        if (cnt_reg < CW'(need))
        begin
            err = sme_pkg::ERR_UNDER;
        end
        else
        begin
            case (op_reg)
                sme_pkg::OP_LOAD:
                    err = idx_bad ? sme_pkg::ERR_LOCAL :
                          (full ? sme_pkg::ERR_OVER : sme_pkg::ERR_NONE);
                sme_pkg::OP_STORE:
                    err = idx_bad ? sme_pkg::ERR_LOCAL :
                          ((cnt_reg == '0) ? sme_pkg::ERR_UNDER : sme_pkg::ERR_NONE);
                sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_IN:
                    err = full ? sme_pkg::ERR_OVER : sme_pkg::ERR_NONE;
                sme_pkg::OP_DIV, sme_pkg::OP_REM:
                    err = (a == '0) ? sme_pkg::ERR_DIVZ : sme_pkg::ERR_NONE;
                sme_pkg::OP_JMP, sme_pkg::OP_JE, sme_pkg::OP_JNE, sme_pkg::OP_JG,
                sme_pkg::OP_JGE, sme_pkg::OP_JL, sme_pkg::OP_JLE:
                    err = (take && tgt_bad) ? sme_pkg::ERR_JUMP : sme_pkg::ERR_NONE;
                sme_pkg::OP_NOP, sme_pkg::OP_POP, sme_pkg::OP_INC, sme_pkg::OP_DEC,
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_AND,
                sme_pkg::OP_OR, sme_pkg::OP_XOR, sme_pkg::OP_NOT, sme_pkg::OP_NEG,
                sme_pkg::OP_SHL, sme_pkg::OP_SHR, sme_pkg::OP_CMP, sme_pkg::OP_OUT,
                sme_pkg::OP_RET:
                    err = sme_pkg::ERR_NONE;
                default:
                    err = sme_pkg::ERR_BADOP;
            endcase
        end

        case (op_reg)
            sme_pkg::OP_ADD: alu_r = b + a;
            sme_pkg::OP_SUB: alu_r = b - a;
            sme_pkg::OP_MUL: alu_r = W'(b * a);
            sme_pkg::OP_DIV: alu_r = (a[W-1] != b[W-1]) ? (-d_q) : d_q;
            sme_pkg::OP_REM: alu_r = b[W-1] ? (-d_r) : d_r;
            sme_pkg::OP_AND: alu_r = b & a;
            sme_pkg::OP_OR:  alu_r = b | a;
            sme_pkg::OP_XOR: alu_r = b ^ a;
            sme_pkg::OP_SHL: alu_r = (a[W-1:5] != '0) ? '0 : (b << a[4:0]);
            sme_pkg::OP_SHR: alu_r = (a[W-1:5] != '0) ? {W{b[W-1]}} :
                                     W'($signed(b) >>> a[4:0]);
            default:         alu_r = '0;
        endcase

        new_cnt   = cnt_reg;
        new_tos   = a;
        stk_we    = 1'b0;
        widx      = cnt_reg[AW-1:0];
        wval      = '0;
        lcl_we    = 1'b0;
        flags_we  = 1'b0;
        new_flags = (a == b) ? sme_pkg::F_EQ : sme_pkg::F_NE;
        if ($signed(a) < $signed(b))
        begin
            new_flags = new_flags | sme_pkg::F_GT;
        end
        if ($signed(b) < $signed(a))
        begin
            new_flags = new_flags | sme_pkg::F_LT;
        end
        val_set = 1'b0;
        value   = '0;
        outv    = 1'b0;
        ret     = 1'b0;
        jt      = 1'b0;
        target  = '0;

        if (err == sme_pkg::ERR_NONE)
        begin
            case (op_reg)
                sme_pkg::OP_LOAD, sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_IN:
                begin
                    case (op_reg)
                        sme_pkg::OP_LOAD: wval = lval;
                        sme_pkg::OP_PUSH: wval = opnd_reg;
                        sme_pkg::OP_DUP:  wval = a;
                        default:          wval = {{(W-9){inb_reg[8]}}, inb_reg};
                    endcase
                    new_cnt = cnt_reg + CW'(1);
                    new_tos = wval;
                    stk_we  = 1'b1;
                    widx    = cnt_reg[AW-1:0];
                end
                sme_pkg::OP_STORE, sme_pkg::OP_POP, sme_pkg::OP_OUT:
                begin
                    lcl_we  = op_reg == sme_pkg::OP_STORE;
                    new_cnt = cnt_reg - CW'(1);
                    new_tos = b;
                    if (op_reg == sme_pkg::OP_OUT)
                    begin
                        val_set = 1'b1;
                        outv    = 1'b1;
                        value   = {{(W-8){1'b0}}, a[7:0]};
                    end
                end
                sme_pkg::OP_INC, sme_pkg::OP_DEC, sme_pkg::OP_NOT, sme_pkg::OP_NEG:
                begin
                    case (op_reg)
                        sme_pkg::OP_INC: wval = a + W'(1);
                        sme_pkg::OP_DEC: wval = a - W'(1);
                        sme_pkg::OP_NOT: wval = ~a;
                        default:         wval = -a;
                    endcase
                    new_tos = wval;
                    stk_we  = 1'b1;
                    widx    = AW'(cnt_reg - CW'(1));
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_REM, sme_pkg::OP_AND, sme_pkg::OP_OR, sme_pkg::OP_XOR,
                sme_pkg::OP_SHL, sme_pkg::OP_SHR:
                begin
                    wval    = alu_r;
                    new_cnt = cnt_reg - CW'(1);
                    new_tos = alu_r;
                    stk_we  = 1'b1;
                    widx    = idx_b;
                end
                sme_pkg::OP_CMP:
                begin
                    flags_we = 1'b1;
                    new_cnt  = cnt_reg - CW'(2);
                    new_tos  = c;
                end
                sme_pkg::OP_JMP, sme_pkg::OP_JE, sme_pkg::OP_JNE, sme_pkg::OP_JG,
                sme_pkg::OP_JGE, sme_pkg::OP_JL, sme_pkg::OP_JLE:
                begin
                    jt     = take;
                    target = take ? tgt[15:0] : 16'd0;
                end
                sme_pkg::OP_RET:
                begin
                    val_set = 1'b1;
                    ret     = 1'b1;
                    value   = (cnt_reg != '0) ? a : '0;
                    new_cnt = '0;
                end
                default:
                begin
                    new_cnt = cnt_reg;
                end
            endcase
        end

        if (!val_set)
        begin
            value = (new_cnt == '0) ? '0 : new_tos;
        end
    end

    assign sts.div_need = is_div && (err == sme_pkg::ERR_NONE);
    assign sts.div_done = d_done;
    assign sts.out_busy = ovld_reg && !out_rdy;
    assign out_vld      = ovld_reg;
    assign out_data     = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            flags_reg  <= '0;
            liu_reg    <= '0;
            csz_reg    <= '0;
            lvalid_reg <= '0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sme_pkg::REG_LOCALS_IN_USE)
                begin
                    liu_reg <= cfg_wdata[8:0];
                end
                else
                begin
                    csz_reg <= cfg_wdata;
                end
            end
            if (cmd.commit)
            begin
                cnt_reg <= new_cnt;
                if (flags_we)
                begin
                    flags_reg <= new_flags;
                end
                if (lcl_we)
                begin
                    lvalid_reg[lidx] <= 1'b1;
                end
                ovld_reg <= 1'b1;
            end
            else if (out_rdy)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_data[4:0];
            opnd_reg <= in_data[36:5];
            addr_reg <= in_data[52:37];
            inb_reg  <= in_data[61:53];
        end
        if (cmd.commit)
        begin
            tos_reg <= new_tos;
            if (stk_we)
            begin
                stk_mem[widx] <= wval;
            end
            if (lcl_we)
            begin
                lcl_mem[lidx] <= a;
            end
            odata_reg <= {3'd0, err, sme_pkg::DEP_BITS'(new_cnt), target,
                          jt, ret, outv, value};
        end
        rdb_reg  <= stk_mem[idx_b];
        rdc_reg  <= stk_mem[idx_c];
        lrd_reg  <= lcl_mem[lidx];
        lvld_reg <= lvalid_reg[lidx];
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the stack machine execute unit: directed and random instruction streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sme_pkg::*;

    localparam int STACK_MAX = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  error;
        logic [6:0]  stack_depth;
        logic [15:0] jump_target;
        logic        jump_taken;
        logic        returned;
        logic        out_valid;
        logic [31:0] value;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    logic [31:0] stack_mem [STACK_MAX];
    int          depth;
    logic [31:0] locals_mem [256];
    logic [3:0]  flags;
    int          locals_limit;
    int          code_limit;

    result_t     expected_results [$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_off;

    stack_machine_execute_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] top_word();
        return (depth > 0) ? stack_mem[depth-1] : 32'd0;
    endfunction

    function automatic result_t execute_instr(logic [4:0] op, logic [31:0] opnd,
                                              logic [15:0] addr, logic [8:0] inb);
        result_t     r;
        int          need;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] w;
        logic [31:0] ua;
        logic [31:0] ub;
        logic        take;
        longint      tgt;
        bit          val_set;
        r = '0;
        val_set = 0;
        need = 0;
        if ((op >= OP_DUP && op <= OP_NEG) || op == OP_OUT)
            need = (op >= OP_ADD && op <= OP_XOR) ? 2 : 1;
        if (op >= OP_SHL && op <= OP_CMP)
            need = 2;
        a = (depth > 0) ? stack_mem[depth-1] : 32'd0;
        b = (depth > 1) ? stack_mem[depth-2] : 32'd0;
        if (depth < need)
            r.error = ERR_UNDER;
        else if (op == OP_NOP)
            r.error = ERR_NONE;
        else if (op == OP_LOAD || op == OP_STORE)
        begin
            if (longint'(opnd) >= locals_limit || opnd >= 256)
                r.error = ERR_LOCAL;
            else if (op == OP_LOAD)
            begin
                if (depth >= STACK_MAX)
                    r.error = ERR_OVER;
                else
                begin
                    stack_mem[depth] = locals_mem[opnd[7:0]];
                    depth++;
                end
            end
            else if (depth < 1)
                r.error = ERR_UNDER;
            else
            begin
                depth--;
                locals_mem[opnd[7:0]] = stack_mem[depth];
            end
        end
        else if (op == OP_PUSH || op == OP_DUP || op == OP_IN)
        begin
            if (depth >= STACK_MAX)
                r.error = ERR_OVER;
            else
            begin
                if (op == OP_PUSH)
                    w = opnd;
                else if (op == OP_DUP)
                    w = a;
                else
                    w = {{23{inb[8]}}, inb};
                stack_mem[depth] = w;
                depth++;
            end
        end
        else if (op == OP_POP)
            depth--;
        else if (op == OP_INC || op == OP_DEC || op == OP_NOT || op == OP_NEG)
        begin
            case (op)
                OP_INC: w = a + 1;
                OP_DEC: w = a - 1;
                OP_NOT: w = ~a;
                default: w = -a;
            endcase
            stack_mem[depth-1] = w;
        end
        else if (op >= OP_ADD && op <= OP_CMP)
        begin
            if ((op == OP_DIV || op == OP_REM) && a == 0)
                r.error = ERR_DIVZ;
            else if (op == OP_CMP)
            begin
                flags = ((a == b) ? F_EQ : F_NE)
                      | (($signed(b) > $signed(a)) ? F_GT : 4'd0)
                      | (($signed(b) < $signed(a)) ? F_LT : 4'd0);
                depth -= 2;
            end
            else
            begin
                ua = a[31] ? -a : a;
                ub = b[31] ? -b : b;
                case (op)
                    OP_ADD: w = b + a;
                    OP_SUB: w = b - a;
                    OP_MUL: w = b * a;
                    OP_DIV:
                    begin
                        w = ub / ua;
                        if (a[31] != b[31])
                            w = -w;
                    end
                    OP_REM:
                    begin
                        w = ub % ua;
                        if (b[31])
                            w = -w;
                    end
                    OP_AND: w = b & a;
                    OP_OR: w = b | a;
                    OP_XOR: w = b ^ a;
                    OP_SHL: w = (a >= 32) ? 32'd0 : (b << a);
                    default: w = (a >= 32) ? {32{b[31]}} : 32'($signed(b) >>> a);
                endcase
                depth--;
                stack_mem[depth-1] = w;
            end
        end
        else if (op >= OP_JMP && op <= OP_JLE)
        begin
            case (op)
                OP_JMP: take = 1'b1;
                OP_JE: take = |(flags & F_EQ);
                OP_JNE: take = |(flags & F_NE);
                OP_JG: take = |(flags & F_GT);
                OP_JGE: take = |(flags & (F_GT | F_EQ));
                OP_JL: take = |(flags & F_LT);
                default: take = |(flags & (F_LT | F_EQ));
            endcase
            if (take)
            begin
                tgt = longint'(addr) + longint'($signed(opnd));
                if (tgt < 0 || tgt > code_limit)
                    r.error = ERR_JUMP;
                else
                begin
                    r.jump_taken = 1'b1;
                    r.jump_target = tgt[15:0];
                end
            end
        end
        else if (op == OP_OUT)
        begin
            depth--;
            r.value = {24'd0, stack_mem[depth][7:0]};
            r.out_valid = 1'b1;
            val_set = 1;
        end
        else if (op == OP_RET)
        begin
            r.value = top_word();
            depth = 0;
            r.returned = 1'b1;
            val_set = 1;
        end
        else
            r.error = ERR_BADOP;
        if (!val_set)
            r.value = top_word();
        r.stack_depth = depth[6:0];
        return r;
    endfunction

    task automatic send_instr(logic [4:0] op, logic [31:0] opnd, logic [15:0] addr,
                              logic [8:0] inb);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, inb, addr, opnd, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(execute_instr(op, opnd, addr, inb));
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LOCALS_IN_USE)
            locals_limit = val[8:0];
        else
            code_limit = val;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        write_reg(REG_LOCALS_IN_USE, 16'd256);
        write_reg(REG_CODE_SIZE, 16'd100);
        send_instr(OP_POP, 32'd0, 16'd0, 9'd0);
        send_instr(OP_RET, 32'd0, 16'd0, 9'd0);
        send_instr(OP_PUSH, 32'h8000_0000, 16'hFFFF, 9'h1FF);
        send_instr(OP_PUSH, 32'hFFFF_FFFF, 16'd0, 9'd0);
        send_instr(OP_DIV, 32'd0, 16'd0, 9'd0);
        send_instr(OP_PUSH, 32'd0, 16'd0, 9'd0);
        send_instr(OP_REM, 32'd0, 16'd0, 9'd0);
        send_instr(OP_STORE, 32'd255, 16'd0, 9'd0);
        send_instr(OP_LOAD, 32'd255, 16'd0, 9'd0);
        send_instr(OP_LOAD, 32'hFFFF_FFFF, 16'd0, 9'd0);
        send_instr(OP_LOAD, 32'd256, 16'd0, 9'd0);
        send_instr(OP_PUSH, 32'd40, 16'd0, 9'd0);
        send_instr(OP_SHL, 32'd0, 16'd0, 9'd0);
        send_instr(OP_IN, 32'd0, 16'd0, 9'h1FF);
        send_instr(OP_IN, 32'd0, 16'd0, 9'hFF);
        send_instr(OP_CMP, 32'd0, 16'd0, 9'd0);
        send_instr(OP_JL, 32'd100, 16'd0, 9'd0);
        send_instr(OP_JMP, 32'hFFFF_FFFF, 16'd0, 9'd0);
        send_instr(OP_JMP, 32'd101, 16'd0, 9'd0);
        send_instr(OP_JNE, 32'hFFFF_FFF0, 16'd16, 9'd0);
        send_instr(OP_OUT, 32'd0, 16'd0, 9'd0);
        send_instr(5'd31, 32'd0, 16'd0, 9'd0);
        send_instr(OP_RET, 32'd0, 16'd0, 9'd0);
        drain();
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 40);
            4: return -$urandom_range(0, 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(int count, int max_depth);
        logic [4:0]  op;
        logic [31:0] opnd;
        logic [8:0]  inb;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom_range(0, 31);
            if (depth < 3 && $urandom_range(0, 2) != 0)
                op = ($urandom_range(0, 1) != 0) ? OP_PUSH : OP_IN;
            else if (depth > max_depth && $urandom_range(0, 1) != 0)
                op = OP_POP;
            if (op == OP_RET && $urandom_range(0, 3) != 0)
                op = OP_NOP;
            if (op == OP_LOAD || op == OP_STORE)
                opnd = ($urandom_range(0, 7) == 0) ? random_word() : $urandom_range(0, 300);
            else if (op >= OP_JMP && op <= OP_JLE)
                opnd = ($urandom_range(0, 3) == 0) ? random_word()
                                                   : 32'($signed($urandom_range(0, 200)) - 100);
            else
                opnd = random_word();
            inb = ($urandom_range(0, 7) == 0) ? 9'h1FF : 9'($urandom_range(0, 255));
            send_instr(op, opnd, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300)),
                       inb);
        end
        drain();
    endtask

    task automatic test_overflow_and_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 70; i++)
            send_instr(OP_PUSH, random_word(), 16'd0, 9'd0);
        send_instr(OP_DUP, 32'd0, 16'd0, 9'd0);
        send_instr(OP_LOAD, 32'd1, 16'd0, 9'd0);
        send_instr(OP_RET, 32'd0, 16'd0, 9'd0);
        drain();
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        hold_off = 1'b0;
        depth = 0;
        flags = '0;
        locals_limit = 0;
        code_limit = 0;
        for (int i = 0; i < 256; i++)
            locals_mem[i] = '0;
        for (int i = 0; i < STACK_MAX; i++)
            stack_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        write_reg(REG_LOCALS_IN_USE, 16'd0);
        write_reg(REG_CODE_SIZE, 16'd0);
        test_random(200, 8);
        write_reg(REG_LOCALS_IN_USE, 16'd17);
        write_reg(REG_CODE_SIZE, 16'd65535);
        test_random(500, 20);
        test_overflow_and_backpressure();
        write_reg(REG_LOCALS_IN_USE, 16'd256);
        write_reg(REG_CODE_SIZE, 16'd250);
        test_random(600, 70);
        write_reg(REG_LOCALS_IN_USE, 16'd300);
        write_reg(REG_CODE_SIZE, 16'd120);
        test_random(550, 12);
        if (mismatches == 0)
            $display("stack_machine_execute_unit regression: pass");
        else
            $display("stack_machine_execute_unit regression: fail");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[60:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value %h/%h out %b/%b ret %b/%b jmp %b/%b tgt %h/%h dep %0d/%0d err %0d/%0d",
                                 want.value, got.value, want.out_valid, got.out_valid,
                                 want.returned, got.returned, want.jump_taken, got.jump_taken,
                                 want.jump_target, got.jump_target, want.stack_depth,
                                 got.stack_depth, want.error, got.error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stack_machine_execute_unit regression: fail");
            $finish;
        end
    end
endmodule
